/* rtl/kem_pkg.sv */
// Shared types, constants and the fixed key table for the key event mapper.
// No dependencies; the files that use this package refer to it by scoped names.
`timescale 1ns / 1ps

package kem_pkg;

    // Matrix geometry
    localparam int ROW_COUNT = 8;
    localparam int ROW_W     = 3;
    localparam logic [ROW_W-1:0] SHIFT_ROW = 3'd7;

    // Key codes of the two shift keys
    localparam logic [7:0] CODE_LEFT_SHIFT  = 8'd117;
    localparam logic [7:0] CODE_RIGHT_SHIFT = 8'd118;

    // Bits of the held-shift pair and of the shift row
    localparam logic [1:0] HELD_LEFT      = 2'b01;
    localparam logic [1:0] HELD_RIGHT     = 2'b10;
    localparam logic [7:0] SHIFT_COL_LEFT = 8'h01;
    localparam logic [7:0] SHIFT_COLS_OFF = 8'hfc;

    // Result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // One decoded table entry
    typedef struct packed {
        logic             present;
        logic [ROW_W-1:0] row;
        logic             force_shift;
        logic             drop_shift;
        logic [7:0]       mask;
    } t_rom_entry;

    // Everything one key event reports, queued as a single record
    typedef struct packed {
        logic             has_shift;
        logic [7:0]       shift_value;
        logic [ROW_W-1:0] row_idx;
        logic [7:0]       row_value;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result data;
    } t_q_push;

    function automatic t_rom_entry rom_ent(input logic [ROW_W-1:0] r, input logic [7:0] m,
                                           input logic f, input logic d);
        t_rom_entry e;
        e.present     = 1'b1;
        e.row         = r;
        e.force_shift = f;
        e.drop_shift  = d;
        e.mask        = m;
        return e;
    endfunction

    // Key table: zero-based row, column mask, force-shift and drop-shift flags
    function automatic t_rom_entry rom_lookup(input logic [7:0] code);
        t_rom_entry e;
        e = '0;
        unique case (code)
            8'd1:                     e = rom_ent(3'd6, 8'h80, 1'b0, 1'b0);
            8'd2, 8'd12:              e = rom_ent(3'd4, 8'h01, 1'b0, 1'b0);
            8'd3, 8'd13, 8'd102:      e = rom_ent(3'd4, 8'h02, 1'b0, 1'b0);
            8'd4, 8'd14, 8'd77:       e = rom_ent(3'd4, 8'h04, 1'b0, 1'b0);
            8'd5, 8'd15, 8'd99:       e = rom_ent(3'd4, 8'h08, 1'b0, 1'b0);
            8'd6, 8'd16, 8'd98:       e = rom_ent(3'd4, 8'h10, 1'b0, 1'b0);
            8'd7, 8'd17, 8'd101:      e = rom_ent(3'd4, 8'h20, 1'b0, 1'b0);
            8'd8, 8'd18, 8'd93:       e = rom_ent(3'd4, 8'h40, 1'b0, 1'b0);
            8'd9, 8'd19:              e = rom_ent(3'd4, 8'h80, 1'b0, 1'b0);
            8'd10, 8'd20, 8'd108:     e = rom_ent(3'd5, 8'h01, 1'b0, 1'b0);
            8'd11, 8'd21, 8'd109:     e = rom_ent(3'd5, 8'h02, 1'b0, 1'b0);
            8'd22, 8'd48:             e = rom_ent(3'd0, 8'h02, 1'b0, 1'b0);
            8'd23, 8'd49:             e = rom_ent(3'd0, 8'h04, 1'b0, 1'b0);
            8'd24, 8'd50:             e = rom_ent(3'd0, 8'h08, 1'b0, 1'b0);
            8'd25, 8'd51:             e = rom_ent(3'd0, 8'h10, 1'b0, 1'b0);
            8'd26, 8'd52:             e = rom_ent(3'd0, 8'h20, 1'b0, 1'b0);
            8'd27, 8'd53:             e = rom_ent(3'd0, 8'h40, 1'b0, 1'b0);
            8'd28, 8'd54:             e = rom_ent(3'd0, 8'h80, 1'b0, 1'b0);
            8'd29, 8'd55:             e = rom_ent(3'd1, 8'h01, 1'b0, 1'b0);
            8'd30, 8'd56:             e = rom_ent(3'd1, 8'h02, 1'b0, 1'b0);
            8'd31, 8'd57:             e = rom_ent(3'd1, 8'h04, 1'b0, 1'b0);
            8'd32, 8'd58:             e = rom_ent(3'd1, 8'h08, 1'b0, 1'b0);
            8'd33, 8'd59:             e = rom_ent(3'd1, 8'h10, 1'b0, 1'b0);
            8'd34, 8'd60:             e = rom_ent(3'd1, 8'h20, 1'b0, 1'b0);
            8'd35, 8'd61:             e = rom_ent(3'd1, 8'h40, 1'b0, 1'b0);
            8'd36, 8'd62:             e = rom_ent(3'd1, 8'h80, 1'b0, 1'b0);
            8'd37, 8'd63:             e = rom_ent(3'd2, 8'h01, 1'b0, 1'b0);
            8'd38, 8'd64:             e = rom_ent(3'd2, 8'h02, 1'b0, 1'b0);
            8'd39, 8'd65:             e = rom_ent(3'd2, 8'h04, 1'b0, 1'b0);
            8'd40, 8'd66:             e = rom_ent(3'd2, 8'h08, 1'b0, 1'b0);
            8'd41, 8'd67:             e = rom_ent(3'd2, 8'h10, 1'b0, 1'b0);
            8'd42, 8'd68:             e = rom_ent(3'd2, 8'h20, 1'b0, 1'b0);
            8'd43, 8'd69:             e = rom_ent(3'd2, 8'h40, 1'b0, 1'b0);
            8'd44, 8'd70:             e = rom_ent(3'd2, 8'h80, 1'b0, 1'b0);
            8'd45, 8'd71:             e = rom_ent(3'd3, 8'h01, 1'b0, 1'b0);
            8'd46, 8'd72:             e = rom_ent(3'd3, 8'h02, 1'b0, 1'b0);
            8'd47, 8'd73:             e = rom_ent(3'd3, 8'h04, 1'b0, 1'b0);
            8'd76:                    e = rom_ent(3'd4, 8'h80, 1'b1, 1'b0);
            8'd78:                    e = rom_ent(3'd5, 8'h20, 1'b1, 1'b0);
            8'd79:                    e = rom_ent(3'd5, 8'h20, 1'b0, 1'b0);
            8'd80:                    e = rom_ent(3'd5, 8'h20, 1'b0, 1'b1);
            8'd81, 8'd92:             e = rom_ent(3'd5, 8'h08, 1'b0, 1'b0);
            8'd82:                    e = rom_ent(3'd5, 8'h08, 1'b1, 1'b0);
            8'd83:                    e = rom_ent(3'd5, 8'h04, 1'b1, 1'b0);
            8'd84:                    e = rom_ent(3'd5, 8'h04, 1'b0, 1'b0);
            8'd85, 8'd133:            e = rom_ent(3'd6, 8'h02, 1'b0, 1'b0);
            8'd86:                    e = rom_ent(3'd5, 8'h80, 1'b0, 1'b1);
            8'd87, 8'd103:            e = rom_ent(3'd5, 8'h80, 1'b0, 1'b0);
            8'd88:                    e = rom_ent(3'd5, 8'h40, 1'b0, 1'b1);
            8'd89, 8'd111:            e = rom_ent(3'd5, 8'h40, 1'b0, 1'b0);
            8'd90:                    e = rom_ent(3'd5, 8'h04, 1'b0, 1'b1);
            8'd91, 8'd110:            e = rom_ent(3'd5, 8'h10, 1'b0, 1'b0);
            8'd95:                    e = rom_ent(3'd4, 8'h08, 1'b1, 1'b0);
            8'd96:                    e = rom_ent(3'd0, 8'h01, 1'b0, 1'b1);
            8'd117:                   e = rom_ent(3'd7, 8'h01, 1'b0, 1'b0);
            8'd118:                   e = rom_ent(3'd7, 8'h02, 1'b0, 1'b0);
            8'd121, 8'd122:           e = rom_ent(3'd7, 8'h04, 1'b0, 1'b0);
            8'd125, 8'd138:           e = rom_ent(3'd6, 8'h04, 1'b0, 1'b0);
            8'd132:                   e = rom_ent(3'd6, 8'h20, 1'b0, 1'b0);
            8'd141:                   e = rom_ent(3'd7, 8'h08, 1'b0, 1'b0);
            8'd143, 8'd144:           e = rom_ent(3'd6, 8'h01, 1'b0, 1'b0);
            8'd150, 8'd151:           e = rom_ent(3'd6, 8'h08, 1'b0, 1'b0);
            8'd152, 8'd153:           e = rom_ent(3'd6, 8'h10, 1'b0, 1'b0);
            8'd154, 8'd155:           e = rom_ent(3'd6, 8'h20, 1'b0, 1'b0);
            8'd156, 8'd157:           e = rom_ent(3'd6, 8'h40, 1'b0, 1'b0);
            8'd159:                   e = rom_ent(3'd7, 8'h10, 1'b0, 1'b0);
            8'd160:                   e = rom_ent(3'd7, 8'h20, 1'b0, 1'b0);
            8'd161:                   e = rom_ent(3'd7, 8'h40, 1'b0, 1'b0);
            8'd162:                   e = rom_ent(3'd4, 8'h01, 1'b1, 1'b0);
            default:                  e = '0;
        endcase
        return e;
    endfunction

endpackage

/* rtl/kem_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module kem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, and register the read (old data on a same-address collision)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/kem_update.sv */
// Row update engine: key table lookup, held-shift tracking and the
// read-modify-write of the matrix rows. Uses kem_pkg and kem_ram.
`timescale 1ns / 1ps

module kem_update (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_in_fire,
    input  logic [7:0]         i_key_code,
    input  logic               i_pressed,
    output logic               o_s1_busy,
    output kem_pkg::t_q_push   o_push
);

    // Configuration and held-shift state
    logic       r_merge;
    logic [1:0] r_shift_held;
    logic [1:0] n_shift_held;

    // Row valid bits stand in for clearing the RAM at reset
    logic [kem_pkg::ROW_COUNT-1:0] r_row_valid;

    // Shift row lives in a register, the other rows in the RAM
    logic [7:0] r_shift_row;
    logic [7:0] n_shift_row;

    // Stage one: the event whose row read is returning
    logic                      r_s1_valid;
    logic [kem_pkg::ROW_W-1:0] r_s1_row;
    logic [7:0]                r_s1_mask;
    logic                      r_s1_force;
    logic                      r_s1_drop;
    logic                      r_s1_down;
    logic [1:0]                r_s1_held;
    logic                      r_s1_ram_ok;
    logic                      r_s1_fwd;
    logic [7:0]                r_fwd_data;

    logic [7:0]          code_eff;
    kem_pkg::t_rom_entry ent;
    logic [7:0]          ram_rdata;
    logic                ram_we;
    logic [7:0]          old_row;
    logic [7:0]          key_new;
    logic [7:0]          shift_base;

    // Fold right shift onto left shift when asked, then look the code up
    always_comb begin
        code_eff = i_key_code;
        if (r_merge && (i_key_code == kem_pkg::CODE_RIGHT_SHIFT)) begin
            code_eff = kem_pkg::CODE_LEFT_SHIFT;
        end
        ent = kem_pkg::rom_lookup(code_eff);
        n_shift_held = r_shift_held;
        if (code_eff == kem_pkg::CODE_LEFT_SHIFT) begin
            n_shift_held = i_pressed ? (r_shift_held | kem_pkg::HELD_LEFT)
                                     : (r_shift_held & kem_pkg::HELD_RIGHT);
        end
        if (code_eff == kem_pkg::CODE_RIGHT_SHIFT) begin
            n_shift_held = i_pressed ? (r_shift_held | kem_pkg::HELD_RIGHT)
                                     : (r_shift_held & kem_pkg::HELD_LEFT);
        end
    end

    kem_ram #(
        .WIDTH (8),
        .DEPTH (kem_pkg::ROW_COUNT)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_row),
        .i_wdata (key_new),
        .i_raddr (ent.row),
        .o_rdata (ram_rdata)
    );

    // Modify the row, then apply the shift flags to the shift row
    always_comb begin
        priority if (r_s1_row == kem_pkg::SHIFT_ROW) begin
            old_row = r_shift_row;
        end else if (r_s1_fwd) begin
            old_row = r_fwd_data;
        end else if (r_s1_ram_ok) begin
            old_row = ram_rdata;
        end else begin
            old_row = '0;
        end
        key_new = r_s1_down ? (old_row | r_s1_mask) : (old_row & ~r_s1_mask);
        shift_base = (r_s1_row == kem_pkg::SHIFT_ROW) ? key_new : r_shift_row;
        n_shift_row = shift_base;
        if (r_s1_down) begin
            if (r_s1_force) begin
                n_shift_row = n_shift_row | kem_pkg::SHIFT_COL_LEFT;
            end
            if (r_s1_drop) begin
                n_shift_row = n_shift_row & kem_pkg::SHIFT_COLS_OFF;
            end
        end else if (r_s1_force || r_s1_drop) begin
            n_shift_row = (shift_base & kem_pkg::SHIFT_COLS_OFF) | {6'b0, r_s1_held};
        end
        ram_we = r_s1_valid && (r_s1_row != kem_pkg::SHIFT_ROW);
    end

    // Hold control state, advance stage one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_merge      <= 1'b0;
            r_shift_held <= '0;
            r_row_valid  <= '0;
            r_shift_row  <= '0;
            r_s1_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_merge <= i_cfg_wdata;
            end
            if (i_in_fire) begin
                r_shift_held <= n_shift_held;
            end
            if (ram_we) begin
                r_row_valid[r_s1_row] <= 1'b1;
            end
            if (r_s1_valid) begin
                r_shift_row <= n_shift_row;
            end
            r_s1_valid <= i_in_fire && ent.present;
        end
    end

    // Stage one payload, with forwarding of a write that races the read
    always_ff @(posedge i_clk) begin
        if (i_in_fire) begin
            r_s1_row    <= ent.row;
            r_s1_mask   <= ent.mask;
            r_s1_force  <= ent.force_shift;
            r_s1_drop   <= ent.drop_shift;
            r_s1_down   <= i_pressed;
            r_s1_held   <= n_shift_held;
            r_s1_ram_ok <= r_row_valid[ent.row];
            r_s1_fwd    <= ram_we && (r_s1_row == ent.row);
            r_fwd_data  <= key_new;
        end
    end

    assign o_s1_busy             = r_s1_valid;
    assign o_push.valid          = r_s1_valid;
    assign o_push.data.has_shift = r_s1_force || r_s1_drop;
    assign o_push.data.shift_value = n_shift_row;
    assign o_push.data.row_idx   = r_s1_row;
    assign o_push.data.row_value = (r_s1_row == kem_pkg::SHIFT_ROW) ? n_shift_row : key_new;

endmodule

/* rtl/kem_outq.sv */
// Result queue: holds one record per key event and plays it out as one or
// two output transactions. Uses kem_pkg.
`timescale 1ns / 1ps

module kem_outq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  kem_pkg::t_q_push            i_push,
    output logic [kem_pkg::QCNT_W-1:0]  o_count,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [2:0]                  o_row_index,
    output logic [7:0]                  o_row_value,
    output logic                        o_last
);

    kem_pkg::t_result r_q [kem_pkg::QUEUE_DEPTH];
    logic [kem_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [kem_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [kem_pkg::QCNT_W-1:0] r_count;
    logic                       r_phase;

    kem_pkg::t_result head;
    logic             show_shift;
    logic             out_fire;
    logic             pop;

    // Present the shift row first when the head record carries one
    always_comb begin
        head       = r_q[r_rd_ptr];
        show_shift = head.has_shift && !r_phase;
        out_fire   = o_valid && !i_stall;
        pop        = out_fire && !show_shift;
    end

    assign o_valid     = (r_count != '0);
    assign o_row_index = show_shift ? kem_pkg::SHIFT_ROW : head.row_idx;
    assign o_row_value = show_shift ? head.shift_value : head.row_value;
    assign o_last      = !show_shift;
    assign o_count     = r_count;

    // Advance pointers, count and phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_phase  <= 1'b0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (out_fire) begin
                r_phase <= show_shift;
            end
            unique case ({i_push.valid, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Store the record
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_q[r_wr_ptr] <= i_push.data;
        end
    end

endmodule

/* rtl/key_event_to_matrix_mapper.sv */
// Key event to keyboard matrix mapper: top level. Uses kem_pkg, kem_update and kem_outq.
//
// Input channel (i_valid / o_stall): one key event per transaction, a key code
// and a pressed flag. Output channel (o_valid / i_stall): matrix row reports,
// each a row index, the row's new value and a last flag.
// An event whose code has no table entry gives no transaction. An ordinary key
// gives one transaction (last = 1). A key with a force-shift or drop-shift flag
// gives two: the shift row (row 7, last = 0), then the key's row (last = 1).
// The first report is presented once the event has passed stage one and entered
// the result queue. The row RAM is read at acceptance and written back in the
// following cycle; a write that collides with the next event's read is forwarded.
// Throughput: one event per cycle for ordinary keys while the output is taken
// every cycle; a flagged key needs two reports on the single output port.
// Reset (synchronous, active low) clears the matrix, the held shift keys and the
// merge setting at once through per-row valid bits; o_stall is high during reset.
// When the receiver stalls, the current report holds; o_stall rises once three
// events, the reported one included, are queued or in flight.
// i_cfg_we / i_cfg_wdata write the merge-right-shift setting; write only idle.
`timescale 1ns / 1ps

module key_event_to_matrix_mapper (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_key_code,
    input  logic       i_pressed,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_row_index,
    output logic [7:0] o_row_value,
    output logic       o_last
);

    logic                       in_fire;
    logic                       s1_busy;
    kem_pkg::t_q_push           push;
    logic [kem_pkg::QCNT_W-1:0] q_count;
    logic [kem_pkg::QCNT_W-1:0] q_claimed;

    // Hold off input unless the queue has room for the event in flight too
    assign q_claimed = q_count + {{(kem_pkg::QCNT_W-1){1'b0}}, s1_busy};
    assign o_stall   = !i_rst_n || (q_claimed >= kem_pkg::QCNT_W'(kem_pkg::QUEUE_DEPTH - 1));
    assign in_fire   = i_valid && !o_stall;

    kem_update u_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_fire   (in_fire),
        .i_key_code  (i_key_code),
        .i_pressed   (i_pressed),
        .o_s1_busy   (s1_busy),
        .o_push      (push)
    );

    kem_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_count     (q_count),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_row_index (o_row_index),
        .o_row_value (o_row_value),
        .o_last      (o_last)
    );

endmodule

/* rtl/kem_checker.sv */
// Port-level checks for the key event mapper, attached by bind.
// Depends on key_event_to_matrix_mapper's ports only.
`timescale 1ns / 1ps

module kem_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_stall,
    input logic [2:0] i_row_index,
    input logic [7:0] i_row_value,
    input logic       i_last
);

    // A stalled report holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_row_index)
            && $stable(i_row_value) && $stable(i_last))
        else $error("report changed while stalled");

    // A report that is not the last of its event is the shift row
    a_first_is_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last |-> i_row_index == 3'd7)
        else $error("non-final report is not the shift row");

    // The key row follows the shift row without a gap
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_stall && !i_last |=> i_out_valid)
        else $error("second report of an event missing");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind key_event_to_matrix_mapper kem_checker u_kem_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_valid),
    .i_out_stall (i_stall),
    .i_row_index (o_row_index),
    .i_row_value (o_row_value),
    .i_last      (o_last)
);
